/* hw/rtl/klt_pkg.sv */
`timescale 1ns / 1ps

package klt_pkg;

   localparam int POSITION_WIDTH = 16;
   localparam int MAX_TOKEN_LEN  = 255;
   localparam int KW_COUNT       = 12;
   localparam int KW_TEXT_BYTES  = 11;
   localparam int QPTR_W         = 2;
   localparam int QUEUE_DEPTH    = 1 << QPTR_W;

   typedef logic [POSITION_WIDTH-1:0] pos_type;
   typedef logic [7:0]                byte_type;
   typedef logic [KW_COUNT-1:0]       kw_mask_type;

   localparam logic [4:0] KIND_EOF        = 5'd0;
   localparam logic [4:0] KIND_NUMBER     = 5'd1;
   localparam logic [4:0] KIND_KW0        = 5'd2;
   localparam logic [4:0] KIND_VARIABLE   = 5'd14;
   localparam logic [4:0] KIND_STRING     = 5'd15;
   localparam logic [4:0] KIND_INC        = 5'd16;
   localparam logic [4:0] KIND_DEC        = 5'd17;
   localparam logic [4:0] KIND_GE         = 5'd18;
   localparam logic [4:0] KIND_LE         = 5'd19;
   localparam logic [4:0] KIND_EQ         = 5'd20;
   localparam logic [4:0] KIND_ADD_ASSIGN = 5'd21;
   localparam logic [4:0] KIND_SUB_ASSIGN = 5'd22;
   localparam logic [4:0] KIND_ASSIGN     = 5'd23;
   localparam logic [4:0] KIND_COLON      = 5'd24;
   localparam logic [4:0] KIND_GT         = 5'd25;
   localparam logic [4:0] KIND_LT         = 5'd26;
   localparam logic [4:0] KIND_SEMI       = 5'd27;
   localparam logic [4:0] KIND_ERROR      = 5'd28;

   localparam logic [7:0] ERROR_TEXT_LEN = 8'd13;

   localparam logic [3:0] KW_LEN [KW_COUNT] =
      '{4'd5, 4'd8, 4'd9, 4'd8, 4'd2, 4'd7, 4'd8, 4'd11, 4'd3, 4'd3, 4'd8, 4'd5};

   localparam logic [8*KW_TEXT_BYTES-1:0] KW_TEXT [KW_COUNT] =
      '{"print", "printent", "metablhth", "perimene", "an", "telosan",
        "telosgia", "neosfakelos", "gia", "eos", "ka8arise", "sbyse"};

   typedef struct packed {
      logic [4:0] kind;
      logic [7:0] length;
      pos_type    line;
      pos_type    column;
   } token_type;

   typedef struct packed {
      logic      two;
      token_type first;
      token_type second;
   } entry_type;

   function automatic pos_type pos_inc(input pos_type p);
      return (p == {POSITION_WIDTH{1'b1}}) ? p : p + pos_type'(1);
   endfunction

   function automatic logic [7:0] run_inc(input logic [7:0] r);
      return (r == 8'(MAX_TOKEN_LEN)) ? r : r + 8'd1;
   endfunction

   // Text is right-justified in each literal: first character sits highest.
   function automatic byte_type kw_char(input int k, input logic [3:0] idx);
      int pos;
      pos = int'(KW_LEN[k]) - 1 - int'(idx);
      return KW_TEXT[k][pos*8 +: 8];
   endfunction

endpackage

/* hw/rtl/klt_if.sv */
`timescale 1ns / 1ps

interface klt_req_if;
   logic                valid;
   logic                ready;
   klt_pkg::byte_type   source_byte;
   modport source (output valid, output source_byte, input ready);
   modport sink   (input valid, input source_byte, output ready);
endinterface

interface klt_rsp_if;
   logic             valid;
   logic             ready;
   logic [4:0]       token_kind;
   logic [7:0]       token_length;
   klt_pkg::pos_type token_line;
   klt_pkg::pos_type token_column;
   logic             last_of_run;
   modport source (output valid, output token_kind, output token_length,
                   output token_line, output token_column, output last_of_run,
                   input ready);
   modport sink   (input valid, input token_kind, input token_length,
                   input token_line, input token_column, input last_of_run,
                   output ready);
endinterface

/* hw/rtl/klt_front.sv */
`timescale 1ns / 1ps

module klt_front (
   input  logic                clock,
   input  logic                reset,
   klt_req_if.sink             req,
   output logic                push_valid,
   output klt_pkg::entry_type  push_entry,
   input  logic                push_ready
);
   import klt_pkg::*;

   typedef enum logic [2:0] {
      MODE_IDLE, MODE_NUMBER, MODE_IDENT, MODE_STRING, MODE_PENDING
   } mode_type;

   typedef struct packed {
      mode_type    mode;
      byte_type    pending;
      logic [7:0]  run;
      kw_mask_type mask;
      pos_type     line;
      pos_type     col;
      pos_type     start;
   } lex_type;

   lex_type st_ff, st_in;
   logic [1:0] n_tok;
   token_type tok0, tok1;

   function automatic kw_mask_type mask_update(input kw_mask_type m, input logic [7:0] r,
                                               input byte_type b);
      kw_mask_type res;
      res = '0;
      for (int k = 0; k < KW_COUNT; k++) begin
         if (m[k] && (r < 8'(KW_LEN[k])) && (kw_char(k, r[3:0]) == b)) res[k] = 1'b1;
      end
      return res;
   endfunction

   function automatic logic [4:0] ident_kind(input kw_mask_type m, input logic [7:0] r);
      logic [4:0] kd;
      kd = KIND_VARIABLE;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         if (m[k] && (r == 8'(KW_LEN[k]))) kd = KIND_KW0 + 5'(k);
      end
      return kd;
   endfunction

   function automatic token_type mk(input logic [4:0] kd, input logic [7:0] len,
                                    input pos_type ln, input pos_type cl);
      token_type t;
      t.kind = kd; t.length = len; t.line = ln; t.column = cl;
      return t;
   endfunction

   always_comb begin
      byte_type   b;
      logic       is_dig, is_alp, is_spc;
      logic       clear_st, do_idle, ib_emit;
      logic [4:0] pk;
      token_type  tk_m, tk_i;
      b        = req.source_byte;
      is_dig   = (b >= 8'd48) && (b <= 8'd57);
      is_alp   = ((b >= 8'd65) && (b <= 8'd90)) || ((b >= 8'd97) && (b <= 8'd122));
      is_spc   = (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
      st_in    = st_ff;
      clear_st = 1'b0;
      do_idle  = 1'b0;
      ib_emit  = 1'b0;
      pk       = KIND_EOF;
      tk_m     = '0;
      tk_i     = '0;
      n_tok    = 2'd0;

      case (st_ff.mode)
         MODE_NUMBER: begin
            if (is_dig) begin
               st_in.run = run_inc(st_ff.run);
               st_in.col = pos_inc(st_ff.col);
            end else begin
               tk_m = mk(KIND_NUMBER, st_ff.run, st_ff.start, st_ff.col);
               n_tok = 2'd1;
               clear_st = 1'b1;
               do_idle = 1'b1;
            end
         end
         MODE_IDENT: begin
            if (is_alp || is_dig || (b == "_")) begin
               st_in.mask = mask_update(st_ff.mask, st_ff.run, b);
               st_in.run  = run_inc(st_ff.run);
               st_in.col  = pos_inc(st_ff.col);
            end else begin
               tk_m = mk(ident_kind(st_ff.mask, st_ff.run), st_ff.run, st_ff.start, st_ff.col);
               n_tok = 2'd1;
               clear_st = 1'b1;
               do_idle = 1'b1;
            end
         end
         MODE_STRING: begin
            if (b == 8'd34 || b == 8'd0) begin
               st_in.col = pos_inc(st_ff.col);
               tk_m = mk(KIND_STRING, st_ff.run, st_ff.start, st_in.col);
               n_tok = 2'd1;
               clear_st = 1'b1;
               // end of input inside a string also reports eof
               do_idle = (b == 8'd0);
            end else begin
               if (b == 8'd10) begin
                  st_in.line = pos_inc(st_ff.line);
                  st_in.col  = pos_type'(1);
               end else begin
                  st_in.col = pos_inc(st_ff.col);
               end
               st_in.run = run_inc(st_ff.run);
            end
         end
         MODE_PENDING: begin
            if      (st_ff.pending == "+" && b == "+") pk = KIND_INC;
            else if (st_ff.pending == "-" && b == "-") pk = KIND_DEC;
            else if (st_ff.pending == ">" && b == "=") pk = KIND_GE;
            else if (st_ff.pending == "<" && b == "=") pk = KIND_LE;
            else if (st_ff.pending == "=" && b == "=") pk = KIND_EQ;
            else if (st_ff.pending == "+" && b == "=") pk = KIND_ADD_ASSIGN;
            else if (st_ff.pending == "-" && b == "=") pk = KIND_SUB_ASSIGN;
            n_tok = 2'd1;
            clear_st = 1'b1;
            if (pk != KIND_EOF) begin
               st_in.col = pos_inc(pos_inc(st_ff.col));
               tk_m = mk(pk, 8'd2, st_ff.start, st_in.col);
            end else if (st_ff.pending == "=" || st_ff.pending == ">" ||
                         st_ff.pending == "<") begin
               st_in.col = pos_inc(st_ff.col);
               tk_m = mk((st_ff.pending == "=") ? KIND_ASSIGN :
                         ((st_ff.pending == ">") ? KIND_GT : KIND_LT),
                         8'd1, st_ff.start, st_in.col);
               do_idle = 1'b1;
            end else begin
               // lone + or - is an error at its own column
               tk_m = mk(KIND_ERROR, ERROR_TEXT_LEN, st_ff.start, st_ff.col);
               st_in.col = pos_inc(st_ff.col);
               do_idle = 1'b1;
            end
         end
         default: begin
            do_idle = 1'b1;
         end
      endcase

      if (clear_st || do_idle) begin
         st_in.mode    = MODE_IDLE;
         st_in.pending = '0;
         st_in.run     = '0;
         st_in.mask    = '1;
      end

      if (do_idle) begin
         if (b == 8'd0) begin
            ib_emit = 1'b1;
            tk_i = mk(KIND_EOF, 8'd0, st_in.line, st_in.col);
         end else if (is_spc) begin
            if (b == 8'd10) begin
               st_in.line = pos_inc(st_in.line);
               st_in.col  = pos_type'(1);
            end else begin
               st_in.col = pos_inc(st_in.col);
            end
         end else if (is_dig) begin
            st_in.mode  = MODE_NUMBER;
            st_in.start = st_in.line;
            st_in.run   = 8'd1;
            st_in.col   = pos_inc(st_in.col);
         end else if (is_alp) begin
            st_in.mode  = MODE_IDENT;
            st_in.start = st_in.line;
            st_in.mask  = mask_update('1, 8'd0, b);
            st_in.run   = 8'd1;
            st_in.col   = pos_inc(st_in.col);
         end else if (b == 8'd34) begin
            st_in.mode  = MODE_STRING;
            st_in.start = st_in.line;
            st_in.run   = 8'd0;
            st_in.col   = pos_inc(st_in.col);
         end else if (b == "+" || b == "-" || b == "=" || b == ">" || b == "<") begin
            st_in.mode    = MODE_PENDING;
            st_in.pending = b;
            st_in.start   = st_in.line;
         end else if (b == ":" || b == ";") begin
            st_in.col = pos_inc(st_in.col);
            ib_emit = 1'b1;
            tk_i = mk((b == ":") ? KIND_COLON : KIND_SEMI, 8'd1, st_in.line, st_in.col);
         end else begin
            ib_emit = 1'b1;
            tk_i = mk(KIND_ERROR, ERROR_TEXT_LEN, st_in.line, st_in.col);
            st_in.col = pos_inc(st_in.col);
         end
      end

      if (n_tok == 2'd1) begin
         tok0 = tk_m;
         tok1 = tk_i;
         if (ib_emit) n_tok = 2'd2;
      end else begin
         tok0 = tk_i;
         tok1 = '0;
         if (ib_emit) n_tok = 2'd1;
      end
   end

   assign req.ready         = push_ready;
   assign push_valid        = req.valid && push_ready && (n_tok != 2'd0);
   assign push_entry.two    = (n_tok == 2'd2);
   assign push_entry.first  = tok0;
   assign push_entry.second = tok1;

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff.mode    <= MODE_IDLE;
         st_ff.pending <= '0;
         st_ff.run     <= '0;
         st_ff.mask    <= '1;
         st_ff.line    <= pos_type'(1);
         st_ff.col     <= pos_type'(1);
         st_ff.start   <= pos_type'(1);
      end else if (req.valid && push_ready) begin
         st_ff <= st_in;
      end
   end

endmodule

/* hw/rtl/klt_queue.sv */
`timescale 1ns / 1ps

module klt_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   input  klt_pkg::entry_type  push_entry,
   output logic                push_ready,
   output logic                pop_valid,
   output klt_pkg::entry_type  pop_entry,
   input  logic                pop
);
   import klt_pkg::*;

   entry_type         q_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [QPTR_W:0]   count_ff, count_in;

   assign push_ready = (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = q_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push_valid && !pop) count_in = count_ff + (QPTR_W+1)'(1);
      else if (!push_valid && pop) count_in = count_ff - (QPTR_W+1)'(1);
   end

   always_ff @(posedge clock) begin
      if (push_valid) q_ff[wr_ptr_ff] <= push_entry;
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push_valid) wr_ptr_ff <= wr_ptr_ff + QPTR_W'(1);
         if (pop)        rd_ptr_ff <= rd_ptr_ff + QPTR_W'(1);
         count_ff <= count_in;
      end
   end

endmodule

/* hw/rtl/klt_back.sv */
`timescale 1ns / 1ps

module klt_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                entry_valid,
   input  klt_pkg::entry_type  entry,
   output logic                pop,
   klt_rsp_if.source           rsp
);
   import klt_pkg::*;

   entry_type cur_ff;
   logic      have_ff, phase_ff;
   logic      last, xfer;
   token_type tok;

   assign tok  = phase_ff ? cur_ff.second : cur_ff.first;
   assign last = phase_ff || !cur_ff.two;
   assign xfer = have_ff && rsp.ready;
   // load the next entry when empty or when the final token leaves
   assign pop  = entry_valid && (!have_ff || (xfer && last));

   assign rsp.valid        = have_ff;
   assign rsp.token_kind   = tok.kind;
   assign rsp.token_length = tok.length;
   assign rsp.token_line   = tok.line;
   assign rsp.token_column = tok.column;
   assign rsp.last_of_run  = last;

   always_ff @(posedge clock) begin
      if (pop) cur_ff <= entry;
      if (reset) begin
         have_ff  <= 1'b0;
         phase_ff <= 1'b0;
      end else if (pop) begin
         have_ff  <= 1'b1;
         phase_ff <= 1'b0;
      end else if (xfer) begin
         if (last) have_ff <= 1'b0;
         else      phase_ff <= 1'b1;
      end
   end

endmodule

/* hw/rtl/keyword_lexer_tokenizer_core.sv */
`timescale 1ns / 1ps

// Streaming tokenizer: one source byte is taken per cycle whenever the
// four-entry result queue between the lexer front and the output stage has
// room. A byte yields zero, one or two tokens; tokens leave at one per cycle
// from the registered output stage while the response channel is ready, and
// a byte that closes one token and reports another sends both in turn. The
// input sustains one byte per cycle while tokens stay at one per cycle or less.
module keyword_lexer_tokenizer_core (
   input  logic      clock,
   input  logic      reset,
   klt_req_if.sink   req_channel,
   klt_rsp_if.source rsp_channel
);
   import klt_pkg::*;

   logic      push_valid, push_ready, pop_valid, pop;
   entry_type push_entry, pop_entry;

   klt_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_channel),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   klt_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop        (pop)
   );

   klt_back u_back (
      .clock       (clock),
      .reset       (reset),
      .entry_valid (pop_valid),
      .entry       (pop_entry),
      .pop         (pop),
      .rsp         (rsp_channel)
   );

endmodule
